### design/dpls_pkg.sv
// dpls_pkg: shared types, constants and helpers for the depth profile logger sequencer.
// Used by the channel interfaces and every module of the block; depends on nothing.
`default_nettype none

package dpls_pkg;

    // default sizes for the top-level parameters
    localparam int LOG_DEPTH_DEF     = 512;
    localparam int SAMPLE_PERIOD_DEF = 1000;

    // fixed timing constants in milliseconds
    localparam logic [31:0] DONE_REPEAT_MS = 32'd3000;
    localparam logic [31:0] RETX_MS        = 32'd2000;
    localparam logic [31:0] MS_PER_S       = 32'd1000;

    // sequence and sample counter width
    localparam int SEQ_W = 10;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_PROFILE_S  = 2'd0;
    localparam logic [1:0] REG_DEPTH_ZERO = 2'd1;
    localparam logic [1:0] REG_TEAM_ID    = 2'd2;

    // item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_RADIO = 1'b1;

    // received packet commands
    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_ACK   = 3'd3;

    // transmitted frame kinds
    localparam logic [1:0] KIND_PREDIVE   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE    = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;
    localparam logic [1:0] KIND_DATA_DONE = 2'd3;

    // reported phase codes
    localparam logic [2:0] CODE_IDLE      = 3'd0;
    localparam logic [2:0] CODE_PREDIVE   = 3'd1;
    localparam logic [2:0] CODE_PROFILING = 3'd2;
    localparam logic [2:0] CODE_DONE      = 3'd3;
    localparam logic [2:0] CODE_DUMP      = 3'd4;

    // mission phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_PREDIVE   = 5'b00010,
        PH_PROFILING = 5'b00100,
        PH_DONE      = 5'b01000,
        PH_DUMP      = 5'b10000
    } t_phase;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic [31:0]        profile_ms;
        logic signed [23:0] depth_zero;
        logic [15:0]        team;
    } t_cfg;

    // one log entry
    typedef struct packed {
        logic signed [23:0] depth;
        logic [31:0]        stamp;
    } t_log_entry;

    // log memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [SEQ_W-1:0] waddr;
        t_log_entry       wdata;
        logic             re;
        logic [SEQ_W-1:0] raddr;
    } t_mem_req;

    // one result item
    typedef struct packed {
        logic [2:0]         cur_state;
        logic               tx_start;
        logic [1:0]         tx_kind;
        logic [SEQ_W-1:0]   tx_seq;
        logic [31:0]        tx_time_ms;
        logic signed [23:0] tx_depth;
        logic [15:0]        tx_team;
    } t_result;

    // result waiting for the log read
    typedef struct packed {
        t_result res;
        logic    use_log;
        logic    in_range;
    } t_stage;

    // phase to reported code
    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:      code = CODE_IDLE;
            PH_PREDIVE:   code = CODE_PREDIVE;
            PH_PROFILING: code = CODE_PROFILING;
            PH_DONE:      code = CODE_DONE;
            PH_DUMP:      code = CODE_DUMP;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

    // saturating 24-bit signed subtract
    function automatic logic signed [23:0] sat_sub24(input logic signed [23:0] a,
                                                     input logic signed [23:0] b);
        logic signed [24:0] diff;
        logic signed [23:0] res;
        diff = {a[23], a} - {b[23], b};
        if (diff[24] != diff[23]) begin
            res = diff[24] ? 24'sh800000 : 24'sh7FFFFF;
        end else begin
            res = diff[23:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/dpls_if.sv
// dpls_if: valid/ready channels for input items and result items.
// Depends on dpls_pkg for the sequence width.
`default_nettype none

// input item channel
interface dpls_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [31:0]                   now_ms;
    logic signed [23:0]            depth_mm;
    logic                          pkt_ok;
    logic [2:0]                    pkt_cmd;
    logic [dpls_pkg::SEQ_W-1:0]    pkt_seq;

    modport source (output valid, mode, now_ms, depth_mm, pkt_ok, pkt_cmd, pkt_seq,
                    input ready);
    modport sink (input valid, mode, now_ms, depth_mm, pkt_ok, pkt_cmd, pkt_seq,
                  output ready);
endinterface

// result item channel
interface dpls_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    cur_state;
    logic                          tx_start;
    logic [1:0]                    tx_kind;
    logic [dpls_pkg::SEQ_W-1:0]    tx_seq;
    logic [31:0]                   tx_time_ms;
    logic signed [23:0]            tx_depth;
    logic [15:0]                   tx_team;

    modport source (output valid, cur_state, tx_start, tx_kind, tx_seq, tx_time_ms,
                    tx_depth, tx_team, input ready);
    modport sink (input valid, cur_state, tx_start, tx_kind, tx_seq, tx_time_ms,
                  tx_depth, tx_team, output ready);
endinterface

`default_nettype wire

### design/dpls_cfg_regs.sv
// dpls_cfg_regs: APB configuration registers (profile length, depth offset, team id).
// Depends on dpls_pkg for register indexes and the t_cfg bundle.
`default_nettype none

module dpls_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dpls_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dpls_pkg::APB_DW-1:0]   pwdata,
    output logic      [dpls_pkg::APB_DW-1:0]   prdata,
    output logic                               pready,
    output dpls_pkg::t_cfg                     o_cfg
);

    logic [15:0]        r_profile_s;
    logic [31:0]        r_profile_ms;
    logic signed [23:0] r_depth_zero;
    logic [15:0]        r_team;
    logic               w_wr;
    logic [1:0]         w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // register writes; the duration is kept in ms as well for the compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_s  <= '0;
            r_profile_ms <= '0;
            r_depth_zero <= '0;
            r_team       <= '0;
        end else if (w_wr) begin
            case (w_idx)
                dpls_pkg::REG_PROFILE_S: begin
                    r_profile_s  <= pwdata[15:0];
                    r_profile_ms <= 32'(pwdata[15:0]) * dpls_pkg::MS_PER_S;
                end
                dpls_pkg::REG_DEPTH_ZERO: begin
                    r_depth_zero <= pwdata[23:0];
                end
                dpls_pkg::REG_TEAM_ID: begin
                    r_team <= pwdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            dpls_pkg::REG_PROFILE_S:  prdata = 32'(r_profile_s);
            dpls_pkg::REG_DEPTH_ZERO: prdata = 32'(unsigned'(r_depth_zero));
            dpls_pkg::REG_TEAM_ID:    prdata = 32'(r_team);
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg.profile_ms = r_profile_ms;
    assign o_cfg.depth_zero = r_depth_zero;
    assign o_cfg.team       = r_team;

endmodule

`default_nettype wire

### design/dpls_log_mem.sv
// dpls_log_mem: sample log memory, one write port and one registered read port.
// Depends on dpls_pkg for the t_mem_req and t_log_entry types.
`default_nettype none

module dpls_log_mem #(
    parameter int LOG_DEPTH = dpls_pkg::LOG_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire dpls_pkg::t_mem_req   i_req,
    output dpls_pkg::t_log_entry      o_rdata
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    dpls_pkg::t_log_entry r_mem [LOG_DEPTH];
    dpls_pkg::t_log_entry r_rdata;

    // write, and registered read (read returns the old entry)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/dpls_seq.sv
// dpls_seq: mission phase control, log read-modify-write and result pipeline.
// Depends on dpls_pkg, the dpls_in_if/dpls_out_if channels and dpls_log_mem read data.
`default_nettype none

module dpls_seq #(
    parameter int LOG_DEPTH        = dpls_pkg::LOG_DEPTH_DEF,
    parameter int SAMPLE_PERIOD_MS = dpls_pkg::SAMPLE_PERIOD_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire dpls_pkg::t_cfg         i_cfg,
    dpls_in_if.sink                     i_item,
    dpls_out_if.source                  o_result,
    output dpls_pkg::t_mem_req          o_mem_req,
    input  wire dpls_pkg::t_log_entry   i_mem_rdata
);

    localparam logic [dpls_pkg::SEQ_W-1:0] LOG_LIMIT = dpls_pkg::SEQ_W'(LOG_DEPTH);
    localparam logic [31:0] PERIOD_MS = 32'(SAMPLE_PERIOD_MS);

    // mission state
    dpls_pkg::t_phase            r_phase, n_phase;
    logic                        r_sending, n_sending;
    logic [31:0]                 r_start_time, n_start_time;
    logic [31:0]                 r_last_sample_at, n_last_sample_at;
    logic [31:0]                 r_last_send_at, n_last_send_at;
    logic [dpls_pkg::SEQ_W-1:0]  r_sample_count, n_sample_count;
    logic [dpls_pkg::SEQ_W-1:0]  r_dump_seq, n_dump_seq;

    // pipeline
    logic                        r_s1_valid;
    dpls_pkg::t_stage            r_s1, n_s1;
    logic                        r_out_valid;
    dpls_pkg::t_result           r_out, w_out;

    logic                        w_accept;
    logic                        w_s1_adv;
    logic [31:0]                 w_now;
    logic [dpls_pkg::SEQ_W-1:0]  w_raddr;
    logic                        w_sample;

    assign w_now    = i_item.now_ms;
    assign w_s1_adv = !r_out_valid || o_result.ready;
    assign i_item.ready = !r_s1_valid || w_s1_adv;
    assign w_accept = i_item.valid && i_item.ready;
    assign w_raddr  = r_dump_seq - dpls_pkg::SEQ_W'(1);

    // a sample is taken on a profiling tick once the period has run and the log has room
    assign w_sample = (i_item.mode == dpls_pkg::MODE_TICK) && (r_phase == dpls_pkg::PH_PROFILING)
                      && ((w_now - r_last_sample_at) >= PERIOD_MS)
                      && (r_sample_count < LOG_LIMIT);

    // log access: sample write and dump read, both at item transfer
    always_comb begin
        o_mem_req.we          = w_accept && w_sample;
        o_mem_req.waddr       = r_sample_count;
        o_mem_req.wdata.depth = dpls_pkg::sat_sub24(i_item.depth_mm, i_cfg.depth_zero);
        o_mem_req.wdata.stamp = w_now;
        o_mem_req.re          = w_accept;
        o_mem_req.raddr       = w_raddr;
    end

    // next mission state and result for the item
    always_comb begin
        n_phase          = r_phase;
        n_sending        = r_sending;
        n_start_time     = r_start_time;
        n_last_sample_at = r_last_sample_at;
        n_last_send_at   = r_last_send_at;
        n_sample_count   = r_sample_count;
        n_dump_seq       = r_dump_seq;
        n_s1             = '0;

        if (i_item.mode == dpls_pkg::MODE_TICK) begin
            case (r_phase)
                dpls_pkg::PH_PREDIVE: begin
                    if (!r_sending) begin
                        n_s1.res.tx_start   = 1'b1;
                        n_s1.res.tx_kind    = dpls_pkg::KIND_PREDIVE;
                        n_s1.res.tx_time_ms = w_now;
                        n_s1.res.tx_team    = i_cfg.team;
                        n_sending           = 1'b1;
                    end
                end
                dpls_pkg::PH_PROFILING: begin
                    if (w_sample) begin
                        n_sample_count   = r_sample_count + dpls_pkg::SEQ_W'(1);
                        n_last_sample_at = w_now;
                    end
                    if ((w_now - r_start_time) >= i_cfg.profile_ms) begin
                        n_phase = dpls_pkg::PH_DONE;
                    end
                end
                dpls_pkg::PH_DONE: begin
                    if (!r_sending && ((w_now - r_last_send_at) >= dpls_pkg::DONE_REPEAT_MS)) begin
                        n_s1.res.tx_start = 1'b1;
                        n_s1.res.tx_kind  = dpls_pkg::KIND_DONE;
                        n_sending         = 1'b1;
                        n_last_send_at    = w_now;
                    end
                end
                dpls_pkg::PH_DUMP: begin
                    if (!r_sending && ((w_now - r_last_send_at) >= dpls_pkg::RETX_MS)) begin
                        n_s1.res.tx_start = 1'b1;
                        n_s1.res.tx_kind  = dpls_pkg::KIND_SAMPLE;
                        n_s1.res.tx_seq   = r_dump_seq;
                        n_s1.res.tx_team  = i_cfg.team;
                        n_s1.use_log      = 1'b1;
                        n_s1.in_range     = (w_raddr < LOG_LIMIT);
                        n_sending         = 1'b1;
                        n_last_send_at    = w_now;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_sending) begin
            // transmit done; the pre-dive frame leaving starts the profile
            n_sending = 1'b0;
            if (r_phase == dpls_pkg::PH_PREDIVE) begin
                n_phase          = dpls_pkg::PH_PROFILING;
                n_start_time     = w_now;
                n_last_sample_at = w_now;
                n_sample_count   = '0;
            end
        end else if (i_item.pkt_ok) begin
            case (r_phase)
                dpls_pkg::PH_IDLE: begin
                    if (i_item.pkt_cmd == dpls_pkg::CMD_BEGIN) begin
                        n_phase = dpls_pkg::PH_PREDIVE;
                    end
                end
                dpls_pkg::PH_DONE: begin
                    if (i_item.pkt_cmd == dpls_pkg::CMD_SEND) begin
                        n_phase        = dpls_pkg::PH_DUMP;
                        n_dump_seq     = dpls_pkg::SEQ_W'(1);
                        n_last_send_at = '0;
                    end
                end
                dpls_pkg::PH_DUMP: begin
                    if (i_item.pkt_cmd == dpls_pkg::CMD_ACK && i_item.pkt_seq == r_dump_seq) begin
                        n_dump_seq = r_dump_seq + dpls_pkg::SEQ_W'(1);
                        if (r_dump_seq >= r_sample_count) begin
                            n_s1.res.tx_start = 1'b1;
                            n_s1.res.tx_kind  = dpls_pkg::KIND_DATA_DONE;
                            n_sending         = 1'b1;
                            n_phase           = dpls_pkg::PH_IDLE;
                        end else begin
                            n_last_send_at = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        n_s1.res.cur_state = dpls_pkg::phase_code(n_phase);
    end

    // state update at item transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= dpls_pkg::PH_IDLE;
            r_sending        <= 1'b0;
            r_start_time     <= '0;
            r_last_sample_at <= '0;
            r_last_send_at   <= '0;
            r_sample_count   <= '0;
            r_dump_seq       <= '0;
        end else if (w_accept) begin
            r_phase          <= n_phase;
            r_sending        <= n_sending;
            r_start_time     <= n_start_time;
            r_last_sample_at <= n_last_sample_at;
            r_last_send_at   <= n_last_send_at;
            r_sample_count   <= n_sample_count;
            r_dump_seq       <= n_dump_seq;
        end
    end

    // merge the log read into the result
    always_comb begin
        w_out = r_s1.res;
        if (r_s1.use_log && r_s1.in_range) begin
            w_out.tx_time_ms = i_mem_rdata.stamp;
            w_out.tx_depth   = i_mem_rdata.depth;
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (i_item.ready) begin
                r_s1_valid <= w_accept;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_out <= w_out;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.cur_state  = r_out.cur_state;
    assign o_result.tx_start   = r_out.tx_start;
    assign o_result.tx_kind    = r_out.tx_kind;
    assign o_result.tx_seq     = r_out.tx_seq;
    assign o_result.tx_time_ms = r_out.tx_time_ms;
    assign o_result.tx_depth   = r_out.tx_depth;
    assign o_result.tx_team    = r_out.tx_team;

    // log never holds more samples than it has entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sample_count <= LOG_LIMIT)
        else $error("sample count beyond log depth");

    // log is written only while profiling
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> r_phase == dpls_pkg::PH_PROFILING)
        else $error("log write outside profiling");

    // a result without a frame carries empty frame fields
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tx_start) |-> (r_out.tx_kind == '0 && r_out.tx_seq == '0
        && r_out.tx_time_ms == '0 && r_out.tx_depth == '0 && r_out.tx_team == '0))
        else $error("frame fields set with no transfer started");

    // starting a transmission always emits a frame
    a_send_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_sending && !r_sending) |-> n_s1.res.tx_start)
        else $error("sending set without a frame");

    // a stalled read stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1)))
        else $error("read stage lost its item under stall");

endmodule

`default_nettype wire

### design/depth_profile_logger_sequencer_core.sv
// depth_profile_logger_sequencer_core: top level of the depth profile logger sequencer.
// Depends on dpls_pkg, dpls_if, dpls_cfg_regs, dpls_log_mem and dpls_seq.
//
// Usage:
//   i_item carries ticks (mode 0) and radio events (mode 1) with the current time;
//   every transferred item yields exactly one result on o_result, in order.
//   The result gives the phase after the item and, when tx_start is set, the frame
//   to transmit (pre-dive, data sample, done profile or data done).
//   Pipeline: the phase state updates and the log memory read issues at the item
//   transfer, which also fills the read stage; the read data is then merged into the
//   output register, which drives o_result.
//   Throughput: one item per cycle while o_result is not stalled, set by the single
//   phase update at transfer and the registered read port of the sample log.
//   Stall: while o_result.ready is low the output register holds; one more item may
//   enter the read stage, after which i_item.ready drops.
//   Reset (i_rst_n low, synchronous) clears the phase, timers, counters and the
//   configuration registers; the sample log is not cleared and needs no sweep.
//   The user must write configuration through the APB port only while the block is
//   idle; the block itself does not enforce this.
`default_nettype none

module depth_profile_logger_sequencer_core #(
    parameter int LOG_DEPTH        = dpls_pkg::LOG_DEPTH_DEF,
    parameter int SAMPLE_PERIOD_MS = dpls_pkg::SAMPLE_PERIOD_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dpls_in_if.sink                            i_item,
    dpls_out_if.source                         o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dpls_pkg::APB_AW-1:0]   paddr,
    input  wire logic [dpls_pkg::APB_DW-1:0]   pwdata,
    output logic      [dpls_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    dpls_pkg::t_cfg       w_cfg;
    dpls_pkg::t_mem_req   w_mem_req;
    dpls_pkg::t_log_entry w_mem_rdata;

    // configuration registers
    dpls_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sample log
    dpls_log_mem #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    // sequencer and result pipeline
    dpls_seq #(
        .LOG_DEPTH        (LOG_DEPTH),
        .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (i_item),
        .o_result    (o_result),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire
